@@ rtl/core/xxh32_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xxh32_pkg
// Shared constants, job record and helpers for the streaming xxHash32 block.
// ----------------------------------------------------------------------------
package xxh32_pkg;

	localparam logic [31:0] P1 = 32'h9E3779B1;
	localparam logic [31:0] P2 = 32'h85EBCA77;
	localparam logic [31:0] P3 = 32'hC2B2AE3D;
	localparam logic [31:0] P4 = 32'h27D4EB2F;
	localparam logic [31:0] P5 = 32'h165667B1;

	localparam int NUM_LANES  = 4;
	localparam int PEND_DEPTH = 3;
	localparam int JOBQ_DEPTH = 2;

	localparam logic [2:0] FULL_BYTES = 3'd4;
	localparam logic [1:0] PEND_FULL  = 2'd3;

	localparam logic [4:0] ROT_LANE  = 5'd13;
	localparam logic [4:0] ROT_WORD  = 5'd17;
	localparam logic [4:0] ROT_BYTE  = 5'd11;
	localparam logic [4:0] ROT_M0    = 5'd1;
	localparam logic [4:0] ROT_M1    = 5'd7;
	localparam logic [4:0] ROT_M2    = 5'd12;
	localparam logic [4:0] ROT_M3    = 5'd18;

	// One finished message handed from the front to the back.
	// tbc is zero when the last word closed a stripe.
	typedef struct packed {
		logic [NUM_LANES-1:0][31:0]  lanes;
		logic                        stripe;
		logic [31:0]                 len;
		logic [PEND_DEPTH-1:0][31:0] pend;
		logic [1:0]                  cnt;
		logic [31:0]                 tail;
		logic [2:0]                  tbc;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
		return (x << r) | (x >> (6'd32 - {1'b0, r}));
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/xxhash32_stream.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xxhash32_stream
// Streaming xxHash32 over little-endian 32-bit message words.
// ----------------------------------------------------------------------------
// The front takes one word per cycle; a word that closes a 16-byte stripe
// holds the input while the front sits in F_RND and the four lane
// multipliers finish their second product, and every word waits while the
// two-entry job queue is full. The back finalizes one message at a time on
// a single shared 32x32 multiplier: the lane merge and length, then B_ADD
// and B_ROT per leftover word or byte (up to three words plus three bytes),
// then the avalanche states B_AV1 and B_AV2 and the output register.
// The seed is taken at the first word of each message.
module xxhash32_stream import xxh32_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] seed,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      hash_value
);

	q_stat_t q_stat;
	job_t    q_push_job;
	job_t    q_head;
	logic    q_push;
	logic    q_pop;

	xxh32_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.seed      (seed),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_word (data_word),
		.byte_count(byte_count),
		.last      (last),
		.q_stat    (q_stat),
		.push      (q_push),
		.push_job  (q_push_job)
	);

	xxh32_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_push_job),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	xxh32_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("job pushed into a full queue");

	a_pop_filled: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("job popped from an empty queue");

	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid)
		else $error("finished job did not reach the output register");
`endif

endmodule
`default_nettype wire

@@ rtl/core/xxh32_jobq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xxh32_jobq
// Two-entry queue of finished messages between the stripe front and the
// finalization back.
// ----------------------------------------------------------------------------
module xxh32_jobq import xxh32_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output q_stat_t   stat
);

	localparam int PTR_W = $clog2(JOBQ_DEPTH);

	job_t             mem_q [JOBQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign stat.full  = (count_q == (PTR_W+1)'(JOBQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/xxh32_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xxh32_front
// Accepts message words, holds the words of an open stripe, runs the four
// lane rounds when a stripe closes and queues a job on the last word.
// ----------------------------------------------------------------------------
module xxh32_front import xxh32_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] seed,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] data_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        last,
	input  wire q_stat_t     q_stat,
	output logic             push,
	output job_t             push_job
);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_RND  = 2'b10
	} fstate_t;

	fstate_t                     state_q;
	logic [31:0]                 seed_q;
	logic [NUM_LANES-1:0][31:0]  lane_q;
	logic [NUM_LANES-1:0][31:0]  t_s1;
	logic [PEND_DEPTH-1:0][31:0] pend_q;
	logic [1:0]                  cnt_q;
	logic [31:0]                 len_q;
	logic                        stripe_q;
	logic                        fin_q;

	logic                        accept;
	logic                        start;
	logic [NUM_LANES-1:0][31:0]  seed_lanes;
	logic [NUM_LANES-1:0][31:0]  lanes_cur;
	logic [NUM_LANES-1:0][31:0]  stripe_w;
	logic [NUM_LANES-1:0][31:0]  t_next;
	logic [NUM_LANES-1:0][31:0]  round_out;
	logic [2:0]                  bc_eff;
	logic [31:0]                 len_new;
	logic                        stripe_go;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != F_IDLE) || q_stat.full;
	assign accept    = in_valid && !in_stall;

	// Fresh message: nothing counted, nothing held.
	assign start = (len_q == '0) && !stripe_q && (cnt_q == '0);

	assign seed_lanes[0] = seed_q + P1 + P2;
	assign seed_lanes[1] = seed_q + P2;
	assign seed_lanes[2] = seed_q;
	assign seed_lanes[3] = seed_q - P1;

	assign lanes_cur = start ? seed_lanes : lane_q;
	assign bc_eff    = (!last || (byte_count > FULL_BYTES)) ? FULL_BYTES : byte_count;
	assign len_new   = len_q + {29'b0, bc_eff};
	assign stripe_go = (bc_eff == FULL_BYTES) && (cnt_q == PEND_FULL);

	assign stripe_w[0] = pend_q[0];
	assign stripe_w[1] = pend_q[1];
	assign stripe_w[2] = pend_q[2];
	assign stripe_w[3] = data_word;

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			t_next[i]    = lanes_cur[i] + stripe_w[i] * P2;
			round_out[i] = rotl32(t_s1[i], ROT_LANE) * P1;
		end
	end

	always_comb begin
		push     = 1'b0;
		push_job = '0;
		unique case (state_q)
			F_IDLE: begin
				push            = accept && last && !stripe_go;
				push_job.lanes  = lanes_cur;
				push_job.stripe = stripe_q;
				push_job.len    = len_new;
				push_job.pend   = pend_q;
				push_job.cnt    = cnt_q;
				push_job.tail   = data_word;
				push_job.tbc    = bc_eff;
			end
			F_RND: begin
				push            = fin_q;
				push_job.lanes  = round_out;
				push_job.stripe = 1'b1;
				push_job.len    = len_q;
				push_job.pend   = pend_q;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Lane and held-word storage carries no reset.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && accept) begin
			if (stripe_go) begin
				t_s1 <= t_next;
			end else if (!last) begin
				lane_q         <= lanes_cur;
				pend_q[cnt_q]  <= data_word;
			end
		end else if (state_q == F_RND) begin
			lane_q <= round_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			seed_q   <= '0;
			cnt_q    <= '0;
			len_q    <= '0;
			stripe_q <= 1'b0;
			fin_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seed_q <= seed;
			end
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (stripe_go) begin
							len_q   <= len_new;
							cnt_q   <= '0;
							fin_q   <= last;
							state_q <= F_RND;
						end else if (last) begin
							len_q    <= '0;
							cnt_q    <= '0;
							stripe_q <= 1'b0;
						end else begin
							len_q <= len_new;
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				F_RND: begin
					// A closing last word ends the message here.
					stripe_q <= !fin_q;
					if (fin_q) begin
						len_q <= '0;
					end
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/xxh32_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xxh32_back
// Finalizes one queued message on a single shared multiplier: lane merge,
// leftover words and bytes, avalanche, then the output register.
// ----------------------------------------------------------------------------
module xxh32_back import xxh32_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_stat_t q_stat,
	input  wire job_t    head,
	output logic         pop,
	output logic         out_valid,
	input  wire logic    out_stall,
	output logic [31:0]  hash_value
);

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_ADD  = 6'b000010,
		B_ROT  = 6'b000100,
		B_AV1  = 6'b001000,
		B_AV2  = 6'b010000,
		B_DONE = 6'b100000
	} bstate_t;

	bstate_t     state_q;
	logic [31:0] h_q;
	logic [2:0]  idx_q;
	logic        out_valid_q;
	logic [31:0] hash_q;

	logic [2:0]  n_items;
	logic        in_word;
	logic        is_byte;
	logic [1:0]  byte_sel;
	logic [31:0] word_val;
	logic [31:0] item_val;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] prod;
	logic [31:0] h_merge;
	logic [31:0] h_init;
	logic        out_load;

	// Items: held words, then the tail as one word or as single bytes.
	assign n_items  = {1'b0, head.cnt} + ((head.tbc == FULL_BYTES) ? 3'd1 : head.tbc);
	assign in_word  = idx_q < {1'b0, head.cnt};
	assign is_byte  = !in_word && (head.tbc != FULL_BYTES);
	assign byte_sel = 2'(idx_q - {1'b0, head.cnt});
	assign word_val = in_word ? head.pend[idx_q[1:0]] : head.tail;
	assign item_val = is_byte ? {24'b0, head.tail[{byte_sel, 3'b000} +: 8]} : word_val;

	assign h_merge = head.stripe
		? rotl32(head.lanes[0], ROT_M0) + rotl32(head.lanes[1], ROT_M1)
		  + rotl32(head.lanes[2], ROT_M2) + rotl32(head.lanes[3], ROT_M3)
		: head.lanes[2] + P5;
	assign h_init = h_merge + head.len;

	always_comb begin
		unique case (state_q)
			B_ADD: begin
				mul_a = item_val;
				mul_b = is_byte ? P5 : P3;
			end
			B_ROT: begin
				mul_a = is_byte ? rotl32(h_q, ROT_BYTE) : rotl32(h_q, ROT_WORD);
				mul_b = is_byte ? P1 : P4;
			end
			B_AV1: begin
				mul_a = h_q ^ (h_q >> 15);
				mul_b = P2;
			end
			B_AV2: begin
				mul_a = h_q ^ (h_q >> 13);
				mul_b = P3;
			end
			default: begin
				mul_a = h_q;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign out_load = (state_q == B_DONE) && (!out_valid_q || !out_stall);
	assign pop      = out_load;

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				h_q   <= h_init;
				idx_q <= '0;
			end
			B_ADD: begin
				h_q <= h_q + prod;
			end
			B_ROT: begin
				h_q   <= prod;
				idx_q <= idx_q + 1'b1;
			end
			B_AV1, B_AV2: begin
				h_q <= prod;
			end
			default: begin
				h_q <= h_q;
			end
		endcase
		if (out_load) begin
			hash_q <= h_q ^ (h_q >> 16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!q_stat.empty) begin
						state_q <= (n_items == '0) ? B_AV1 : B_ADD;
					end
				end
				B_ADD: begin
					state_q <= B_ROT;
				end
				B_ROT: begin
					state_q <= (idx_q + 1'b1 == n_items) ? B_AV1 : B_ADD;
				end
				B_AV1: begin
					state_q <= B_AV2;
				end
				B_AV2: begin
					state_q <= B_DONE;
				end
				B_DONE: begin
					if (out_load) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
